// ===== src/sttg_pkg.sv =====
// Shared types, constants and register map of the trapezoidal step generator.
package sttg_pkg;

    localparam int POSITION_BITS   = 32;
    localparam int SPEED_FRAC_BITS = 16;

    // Speed word: 16 integer bits and the fraction.
    localparam int SPD_W = 16 + SPEED_FRAC_BITS;

    // Divider numerator: wider of accel << 2F and tick_hz << F.
    localparam int DIV_NUM_W = (16 + 2 * SPEED_FRAC_BITS > 27 + SPEED_FRAC_BITS) ?
                               (16 + 2 * SPEED_FRAC_BITS) : (27 + SPEED_FRAC_BITS);
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // Ramp sum before clamping.
    localparam int RAMP_W = DIV_NUM_W + 1;

    // Command queue between front and back, a power of two.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int CFG_ADDR_W = 5;

    localparam logic [15:0] SPD_LO_RST      = 16'd50;
    localparam logic [15:0] SPD_HI_RST      = 16'd1000;
    localparam logic [15:0] START_SPEED_RST = 16'd100;
    localparam logic [15:0] ACCEL_RST       = 16'd50;
    localparam logic [26:0] TICK_HZ_RST     = 27'd1000000;

    typedef enum logic [2:0] {
        REG_SPD_LO      = 3'd0,
        REG_SPD_HI      = 3'd1,
        REG_START_SPEED = 3'd2,
        REG_ACCEL       = 3'd3,
        REG_TICK_HZ     = 3'd4
    } t_reg_idx;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_MOVE = 1'b1
    } t_op;

    typedef struct packed {
        logic               command;
        logic signed [31:0] target_position;
    } t_in_item;

    typedef struct packed {
        logic               step_pulse;
        logic               direction;
        logic signed [31:0] position;
        logic [15:0]        speed_hz;
        logic               moving;
        logic               move_done;
    } t_out_item;

    typedef struct packed {
        logic [15:0] spd_lo;
        logic [15:0] spd_hi;
        logic [15:0] start_speed;
        logic [15:0] accel;
        logic [26:0] tick_hz;
    } t_cfg;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] target;
    } t_qent;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [SPD_W-1:0]     den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== src/stepper_trapezoid_step_generator.sv =====
// Top level of the trapezoidal step generator: register file and block wiring.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  in      | input     | i_in_valid/o_in_ready | sttg_pkg::t_in_item
//  out     | output    | o_out_valid/i_out_ready | sttg_pkg::t_out_item
//  cfg     | input     | psel/penable/pwrite, pready | paddr, pwdata, prdata
//
// A tick that does not expire and a move request pass from idle through the push state in the back end.
// A tick that issues a step runs the shared divider twice, one quotient bit a cycle,
// first for the speed increment and then, after the clamp, for the step period.
// Synchronous active-low reset restores the register defaults and clears the move.
// Until it is full, the two-entry queue keeps accepting transactions while the back end
// divides or while a finished result waits in the output register for the consumer.
module stepper_trapezoid_step_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sttg_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sttg_pkg::t_out_item                 o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sttg_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    sttg_pkg::t_cfg     r_cfg;
    logic               w_wr;
    logic [2:0]         w_idx;
    logic               w_q_valid;
    sttg_pkg::t_qent    w_q_ent;
    logic               w_q_pop;
    sttg_pkg::t_div_req w_div_req;
    sttg_pkg::t_div_rsp w_div_rsp;

    // The port never stalls; a write lands on the access phase.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spd_lo      <= sttg_pkg::SPD_LO_RST;
            r_cfg.spd_hi      <= sttg_pkg::SPD_HI_RST;
            r_cfg.start_speed <= sttg_pkg::START_SPEED_RST;
            r_cfg.accel       <= sttg_pkg::ACCEL_RST;
            r_cfg.tick_hz     <= sttg_pkg::TICK_HZ_RST;
        end else if (w_wr) begin
            case (w_idx)
                sttg_pkg::REG_SPD_LO:      r_cfg.spd_lo      <= pwdata[15:0];
                sttg_pkg::REG_SPD_HI:      r_cfg.spd_hi      <= pwdata[15:0];
                sttg_pkg::REG_START_SPEED: r_cfg.start_speed <= pwdata[15:0];
                sttg_pkg::REG_ACCEL:       r_cfg.accel       <= pwdata[15:0];
                sttg_pkg::REG_TICK_HZ:     r_cfg.tick_hz     <= pwdata[26:0];
                default: begin
                end
            endcase
        end
    end

    // Read back: zero-extend each register, unused addresses read as zero.
    always_comb begin
        case (w_idx)
            sttg_pkg::REG_SPD_LO:      prdata = 32'(r_cfg.spd_lo);
            sttg_pkg::REG_SPD_HI:      prdata = 32'(r_cfg.spd_hi);
            sttg_pkg::REG_START_SPEED: prdata = 32'(r_cfg.start_speed);
            sttg_pkg::REG_ACCEL:       prdata = 32'(r_cfg.accel);
            sttg_pkg::REG_TICK_HZ:     prdata = 32'(r_cfg.tick_hz);
            default:                   prdata = '0;
        endcase
    end

    // Front end: accept and classify, hold in the queue.
    sttg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (w_q_valid),
        .o_q_ent    (w_q_ent),
        .i_q_pop    (w_q_pop)
    );

    // Shared divider for the speed increment and the step period.
    sttg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Back end: advance the move and issue results.
    sttg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_ent     (w_q_ent),
        .o_q_pop     (w_q_pop),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== src/sttg_front.sv =====
// Input side: accept transactions, classify them and queue them for the back end.
module sttg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sttg_pkg::t_in_item i_in_data,
    output logic              o_q_valid,
    output sttg_pkg::t_qent   o_q_ent,
    input  logic              i_q_pop
);

    sttg_pkg::t_qent                  r_mem [sttg_pkg::Q_DEPTH];
    logic [sttg_pkg::Q_PTR_W-1:0]     r_wr;
    logic [sttg_pkg::Q_PTR_W-1:0]     r_rd;
    logic [sttg_pkg::Q_CNT_W-1:0]     r_cnt;
    logic                             w_push;
    logic                             w_pop;
    sttg_pkg::t_qent                  w_ent;

    assign o_in_ready = (r_cnt != sttg_pkg::Q_CNT_W'(sttg_pkg::Q_DEPTH));
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_ent    = r_mem[r_rd];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_q_pop && o_q_valid;

    always_comb begin
        w_ent.op     = sttg_pkg::t_op'(i_in_data.command);
        w_ent.target = i_in_data.target_position;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== src/sttg_div.sv =====
// Restoring divider, one quotient bit per cycle; a zero divisor counts as one upstream.
module sttg_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sttg_pkg::t_div_req i_req,
    output sttg_pkg::t_div_rsp o_rsp
);

    logic [sttg_pkg::DIV_NUM_W-1:0] r_num;
    logic [sttg_pkg::SPD_W-1:0]     r_rem;
    logic [sttg_pkg::SPD_W-1:0]     r_den;
    logic [sttg_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [sttg_pkg::SPD_W:0]       w_shift;
    logic                           w_ge;

    assign w_shift = {r_rem, r_num[sttg_pkg::DIV_NUM_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_num <= {r_num[sttg_pkg::DIV_NUM_W-2:0], w_ge};
            r_rem <= w_ge ? sttg_pkg::SPD_W'(w_shift - {1'b0, r_den})
                          : sttg_pkg::SPD_W'(w_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= sttg_pkg::DIV_CNT_W'(sttg_pkg::DIV_NUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/sttg_back.sv =====
// Execution side: move state, speed ramp, step issue and the output register.
module sttg_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sttg_pkg::t_cfg      i_cfg,
    input  logic                i_q_valid,
    input  sttg_pkg::t_qent     i_q_ent,
    output logic                o_q_pop,
    output sttg_pkg::t_div_req  o_div_req,
    input  sttg_pkg::t_div_rsp  i_div_rsp,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sttg_pkg::t_out_item o_out_data
);

    localparam int PB = sttg_pkg::POSITION_BITS;
    localparam int F  = sttg_pkg::SPEED_FRAC_BITS;
    localparam int SW = sttg_pkg::SPD_W;
    localparam int NW = sttg_pkg::DIV_NUM_W;
    localparam int RW = sttg_pkg::RAMP_W;

    typedef enum logic [4:0] {
        BS_IDLE    = 5'b00001,
        BS_DIV_INC = 5'b00010,
        BS_CLAMP   = 5'b00100,
        BS_DIV_PER = 5'b01000,
        BS_PUSH    = 5'b10000
    } t_bstate;

    t_bstate                r_state;
    logic signed [PB-1:0]   r_pos;
    logic signed [PB-1:0]   r_goal;
    logic                   r_dir;
    logic [31:0]            r_len;
    logic [31:0]            r_idx;
    logic [SW-1:0]          r_speed;
    logic [31:0]            r_cnt;
    logic                   r_busy;
    logic [RW-1:0]          r_ramp;
    sttg_pkg::t_out_item    r_res;
    logic                   r_out_valid;
    sttg_pkg::t_out_item    r_out_data;

    logic                   w_take;
    logic                   w_is_move;
    logic                   w_start;
    logic                   w_run_exp;
    logic                   w_start_dir;
    logic [PB-1:0]          w_dist;
    logic [31:0]            w_len;
    logic [SW-1:0]          w_start_spd;
    logic [SW-1:0]          w_lo;
    logic [SW-1:0]          w_hi;
    logic [31:0]            w_half;
    logic [RW-1:0]          w_spd_x;
    logic [RW-1:0]          w_inc_x;
    logic [RW-1:0]          w_ramp;
    logic [SW-1:0]          w_clamp;
    logic [31:0]            w_period;
    logic [31:0]            w_cd;
    logic [31:0]            w_idx_next;
    logic signed [PB-1:0]   w_pos_next;
    logic                   w_last;
    logic                   w_out_free;
    sttg_pkg::t_out_item    w_cur;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign w_take    = (r_state == BS_IDLE) && i_q_valid;
    assign o_q_pop   = w_take;
    assign w_is_move = (i_q_ent.op == sttg_pkg::OP_MOVE);
    assign w_start   = !r_busy && (r_pos != r_goal);
    assign w_run_exp = r_busy && (r_cnt == '0);

    // Move set-up: direction, distance and saturated length.
    assign w_start_dir = (r_goal > r_pos);
    assign w_dist      = w_start_dir ? PB'(r_goal - r_pos) : PB'(r_pos - r_goal);
    assign w_len       = ((PB + 32)'(w_dist) > (PB + 32)'(32'hFFFF_FFFF)) ?
                         32'hFFFF_FFFF : 32'(w_dist);

    assign w_start_spd = {i_cfg.start_speed, {F{1'b0}}};
    assign w_lo        = {i_cfg.spd_lo, {F{1'b0}}};
    assign w_hi        = {i_cfg.spd_hi, {F{1'b0}}};

    // Ramp: accelerate over the first half, decelerate over the second.
    assign w_half  = r_len >> 1;
    assign w_spd_x = RW'(r_speed);
    assign w_inc_x = RW'(i_div_rsp.quot);

    always_comb begin
        if ((r_idx < w_half) && (r_speed < w_hi)) begin
            w_ramp = w_spd_x + w_inc_x;
        end else if ((r_idx > w_half) && (r_speed > w_start_spd)) begin
            w_ramp = (w_spd_x > w_inc_x) ? (w_spd_x - w_inc_x) : '0;
        end else begin
            w_ramp = w_spd_x;
        end
    end

    // Clamp: the floor test wins over the ceiling.
    always_comb begin
        if (r_ramp < RW'(w_lo)) begin
            w_clamp = w_lo;
        end else if (r_ramp > RW'(w_hi)) begin
            w_clamp = w_hi;
        end else begin
            w_clamp = SW'(r_ramp);
        end
    end

    // Step period, saturated, and the countdown reload.
    assign w_period   = (i_div_rsp.quot > NW'(32'hFFFF_FFFF)) ?
                        32'hFFFF_FFFF : 32'(i_div_rsp.quot);
    assign w_cd       = (w_period == '0) ? '0 : (w_period - 1'b1);
    assign w_idx_next = r_idx + 1'b1;
    assign w_pos_next = r_dir ? (r_pos + PB'(1)) : (r_pos - PB'(1));
    assign w_last     = (w_idx_next >= r_len);

    always_comb begin
        w_cur.step_pulse = 1'b0;
        w_cur.direction  = r_dir;
        w_cur.position   = 32'(r_pos);
        w_cur.speed_hz   = r_speed[F +: 16];
        w_cur.moving     = r_busy;
        w_cur.move_done  = 1'b0;
    end

    // Divider requests: increment on a move start or expiry, period after the clamp.
    always_comb begin
        o_div_req.start = 1'b0;
        o_div_req.num   = NW'({i_cfg.accel, {(2 * F){1'b0}}});
        o_div_req.den   = (r_speed == '0) ? SW'(1) : r_speed;
        if (w_take && !w_is_move && w_start) begin
            o_div_req.start = 1'b1;
            o_div_req.den   = (w_start_spd == '0) ? SW'(1) : w_start_spd;
        end else if (w_take && !w_is_move && w_run_exp) begin
            o_div_req.start = 1'b1;
        end else if (r_state == BS_CLAMP) begin
            o_div_req.start = 1'b1;
            o_div_req.num   = NW'({i_cfg.tick_hz, {F{1'b0}}});
            o_div_req.den   = (w_clamp == '0) ? SW'(1) : w_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_pos   <= '0;
            r_goal  <= '0;
            r_dir   <= 1'b1;
            r_len   <= '0;
            r_idx   <= '0;
            r_speed <= {sttg_pkg::START_SPEED_RST, {F{1'b0}}};
            r_cnt   <= '0;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                BS_IDLE: begin
                    if (w_take) begin
                        if (w_is_move) begin
                            r_goal  <= PB'(i_q_ent.target);
                            r_res   <= w_cur;
                            r_state <= BS_PUSH;
                        end else if (w_start) begin
                            r_dir   <= w_start_dir;
                            r_len   <= w_len;
                            r_idx   <= '0;
                            r_speed <= w_start_spd;
                            r_cnt   <= '0;
                            r_busy  <= 1'b1;
                            r_state <= BS_DIV_INC;
                        end else if (w_run_exp) begin
                            r_state <= BS_DIV_INC;
                        end else if (r_busy) begin
                            r_cnt   <= r_cnt - 1'b1;
                            r_res   <= w_cur;
                            r_state <= BS_PUSH;
                        end else begin
                            r_res   <= w_cur;
                            r_state <= BS_PUSH;
                        end
                    end
                end
                BS_DIV_INC: begin
                    if (i_div_rsp.done) begin
                        r_ramp  <= w_ramp;
                        r_state <= BS_CLAMP;
                    end
                end
                BS_CLAMP: begin
                    r_speed <= w_clamp;
                    r_state <= BS_DIV_PER;
                end
                BS_DIV_PER: begin
                    if (i_div_rsp.done) begin
                        r_pos            <= w_pos_next;
                        r_idx            <= w_idx_next;
                        r_cnt            <= w_cd;
                        r_busy           <= !w_last;
                        r_res.step_pulse <= 1'b1;
                        r_res.direction  <= r_dir;
                        r_res.position   <= 32'(w_pos_next);
                        r_res.speed_hz   <= r_speed[F +: 16];
                        r_res.moving     <= !w_last;
                        r_res.move_done  <= w_last;
                        r_state          <= BS_PUSH;
                    end
                end
                BS_PUSH: begin
                    if (w_out_free) begin
                        r_state <= BS_IDLE;
                    end
                end
                default: begin
                    r_state <= BS_IDLE;
                end
            endcase
        end
    end

    // Output register: load a finished result, drop it once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == BS_PUSH) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == BS_PUSH) && w_out_free) begin
            r_out_data <= r_res;
        end
    end

endmodule
